### rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the RGB to HSV pipeline.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/rhsv_pkg.sv
// rhsv_pkg: types, widths and codes shared by the RGB to HSV pipeline.
// No dependencies.
package rhsv_pkg;

    localparam int CH_W       = 8;
    localparam int FRAC_W     = 16;
    localparam int CH_MAX     = (1 << CH_W) - 1;
    localparam int DEN_W      = $clog2(6 * CH_MAX + 1);
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = FRAC_W / STEP_BITS;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } pixel_t;

    typedef struct packed {
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] saturation;
        logic [CH_W-1:0]   value;
        logic              frame_end_out;
    } hsv_t;

    // one beat inside the divider pipeline: two restoring divisions side by side
    typedef struct packed {
        logic              valid;
        logic              frame_end;
        logic [CH_W-1:0]   value;
        logic              sat_zero;
        logic              sat_full;
        logic              hue_zero;
        logic [DEN_W-1:0]  rem_s;
        logic [DEN_W-1:0]  den_s;
        logic [FRAC_W-1:0] q_s;
        logic [DEN_W-1:0]  rem_h;
        logic [DEN_W-1:0]  den_h;
        logic [FRAC_W-1:0] q_h;
    } div_t;

endpackage

### rtl/rgb_to_hsv_hexcone.sv
// 6 register stages: 2 front stages (max/min, hue numerator), then
// 4 divider stages retiring 4 quotient bits each for saturation and hue.
// Throughput: one pixel per cycle unless the output stalls.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n, async, active low) clears the stage valid bits only.
// Depends on rhsv_pkg, rhsv_div_stage and assert_macros.svh.
`include "assert_macros.svh"

module rgb_to_hsv_hexcone (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  rhsv_pkg::pixel_t pixel,
    output logic             hsv_valid,
    input  logic             hsv_ready,
    output rhsv_pkg::hsv_t   hsv
);

    localparam int CH_W  = rhsv_pkg::CH_W;
    localparam int DEN_W = rhsv_pkg::DEN_W;

    logic en;

    // stage A: max, min, winning channel, signed difference
    logic                   a_valid_reg;
    logic [CH_W-1:0]        a_mx_reg, a_mx_next;
    logic [CH_W-1:0]        a_mn_reg, a_mn_next;
    logic [1:0]             a_sel_reg, a_sel_next;
    logic signed [CH_W:0]   a_diff_reg, a_diff_next;
    logic                   a_fe_reg;

    // stage B: divider setup
    rhsv_pkg::div_t         b_next;
    rhsv_pkg::div_t         b_reg;
    logic                   b_valid_reg;

    rhsv_pkg::div_t         chain [rhsv_pkg::DIV_STAGES+1];
    rhsv_pkg::div_t         last;

    assign en          = hsv_ready || !hsv_valid;
    assign pixel_ready = en;

    always_comb
    begin
        if (pixel.green >= pixel.red)
        begin
            a_mx_next  = pixel.green;
            a_sel_next = rhsv_pkg::SEL_GREEN;
        end
        else
        begin
            a_mx_next  = pixel.red;
            a_sel_next = rhsv_pkg::SEL_RED;
        end
        if (pixel.blue >= a_mx_next)
        begin
            a_mx_next  = pixel.blue;
            a_sel_next = rhsv_pkg::SEL_BLUE;
        end
        a_mn_next = (pixel.green < pixel.red) ? pixel.green : pixel.red;
        if (pixel.blue < a_mn_next)
        begin
            a_mn_next = pixel.blue;
        end
        case (a_sel_next)
            rhsv_pkg::SEL_RED:
                a_diff_next = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
            rhsv_pkg::SEL_GREEN:
                a_diff_next = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
            default:
                a_diff_next = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pixel_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mx_reg   <= a_mx_next;
            a_mn_reg   <= a_mn_next;
            a_sel_reg  <= a_sel_next;
            a_diff_reg <= a_diff_next;
            a_fe_reg   <= pixel.frame_end;
            b_reg      <= b_next;
        end
    end

    // hue numerator: sector offset * d + diff, folded into [0, 6d)
    always_comb
    begin
        logic [CH_W-1:0]      d;
        logic [DEN_W-1:0]     d6;
        logic [DEN_W-1:0]     off;
        logic signed [DEN_W:0] num;
        d   = a_mx_reg - a_mn_reg;
        d6  = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        case (a_sel_reg)
            rhsv_pkg::SEL_RED:   off = '0;
            rhsv_pkg::SEL_GREEN: off = {2'b00, d, 1'b0};
            default:             off = {1'b0, d, 2'b00};
        endcase
        num = $signed({1'b0, off})
            + $signed({{(DEN_W - CH_W){a_diff_reg[CH_W]}}, a_diff_reg});
        if (num < 0)
        begin
            num = num + $signed({1'b0, d6});
        end
        b_next           = '0;
        b_next.valid     = a_valid_reg;
        b_next.frame_end = a_fe_reg;
        b_next.value     = a_mx_reg;
        b_next.sat_zero  = (a_mx_reg == '0);
        b_next.sat_full  = (a_mn_reg == '0) && (a_mx_reg != '0);
        b_next.hue_zero  = (d == '0);
        b_next.rem_s     = {{(DEN_W - CH_W){1'b0}}, d};
        b_next.den_s     = {{(DEN_W - CH_W){1'b0}}, a_mx_reg};
        b_next.rem_h     = num[DEN_W-1:0];
        b_next.den_h     = d6;
    end

    always_comb
    begin
        chain[0]       = b_reg;
        chain[0].valid = b_valid_reg;
    end

    for (genvar g = 0; g < rhsv_pkg::DIV_STAGES; g++)
    begin : g_div
        rhsv_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    assign last      = chain[rhsv_pkg::DIV_STAGES];
    assign hsv_valid = last.valid;

    always_comb
    begin
        hsv.value         = last.value;
        hsv.frame_end_out = last.frame_end;
        hsv.hue           = last.hue_zero ? '0 : last.q_h;
        if (last.sat_zero)
        begin
            hsv.saturation = '0;
        end
        else if (last.sat_full)
        begin
            hsv.saturation = '1;
        end
        else
        begin
            hsv.saturation = last.q_s;
        end
    end

    `ASSERT_NEXT(a_accept_enters, clk, rst_n, pixel_valid && pixel_ready, a_valid_reg)
    `ASSERT_IMPLY(a_black_zero, clk, rst_n, hsv_valid && hsv.value == '0,
                  hsv.hue == '0 && hsv.saturation == '0)
    `ASSERT_IMPLY(a_grey_hue, clk, rst_n, hsv_valid && hsv.saturation == '0, hsv.hue == '0)
    `ASSERT_NEXT(a_stall_holds_last, clk, rst_n, hsv_valid && !hsv_ready,
                 hsv_valid && $stable(hsv))

endmodule

### rtl/rhsv_div_stage.sv
// rhsv_div_stage: one registered stage of the fraction dividers, STEP_BITS
// quotient bits of saturation and hue per stage. Depends on rhsv_pkg.
module rhsv_div_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  rhsv_pkg::div_t stage_in,
    output rhsv_pkg::div_t stage_out
);

    rhsv_pkg::div_t data_next;
    rhsv_pkg::div_t data_reg;
    logic           valid_reg;

    always_comb
    begin
        logic [rhsv_pkg::DEN_W:0] sh_s;
        logic [rhsv_pkg::DEN_W:0] sh_h;
        data_next = stage_in;
        for (int i = 0; i < rhsv_pkg::STEP_BITS; i++)
        begin
            sh_s = {data_next.rem_s, 1'b0};
            sh_h = {data_next.rem_h, 1'b0};
            if (sh_s >= {1'b0, data_next.den_s})
            begin
                sh_s = sh_s - {1'b0, data_next.den_s};
                data_next.q_s = {data_next.q_s[rhsv_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                data_next.q_s = {data_next.q_s[rhsv_pkg::FRAC_W-2:0], 1'b0};
            end
            if (sh_h >= {1'b0, data_next.den_h})
            begin
                sh_h = sh_h - {1'b0, data_next.den_h};
                data_next.q_h = {data_next.q_h[rhsv_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                data_next.q_h = {data_next.q_h[rhsv_pkg::FRAC_W-2:0], 1'b0};
            end
            data_next.rem_s = sh_s[rhsv_pkg::DEN_W-1:0];
            data_next.rem_h = sh_h[rhsv_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

### dv/rgb_to_hsv_hexcone_tb.sv
`timescale 1ns / 100ps
// rgb_to_hsv_hexcone_tb: self-checking bench for the hexcone RGB to HSV pipeline.
// Directed pixel table then random pixels, scored against table values or an in-bench HSV predictor.
// Depends on rhsv_pkg and rgb_to_hsv_hexcone.
module rgb_to_hsv_hexcone_tb;

    localparam int NUM_DIR        = 22;
    localparam int NUM_RANDOM     = 1578;
    localparam int CALM_FIRST     = 500;
    localparam int CALM_LAST      = 800;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 60;
    localparam int PAUSE_AT       = 1100;
    localparam int IDLE_PCT       = 32;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic             typed;
        rhsv_pkg::pixel_t px;
        rhsv_pkg::hsv_t   hsv;
    } dir_row_t;

    // typed rows carry their expected HSV, the rest go through the predictor
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        {1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 16'd0,     16'd0,     8'd0,   1'b0},
        {1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 16'd0,     16'd0,     8'd0,   1'b1},
        {1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 16'd0,     16'd0,     8'd255, 1'b0},
        {1'b1, 8'd128, 8'd128, 8'd128, 1'b0, 16'd0,     16'd0,     8'd128, 1'b0},
        {1'b1, 8'd1,   8'd1,   8'd1,   1'b0, 16'd0,     16'd0,     8'd1,   1'b0},
        {1'b1, 8'd255, 8'd0,   8'd0,   1'b0, 16'd0,     16'd65535, 8'd255, 1'b0},
        {1'b1, 8'd0,   8'd255, 8'd0,   1'b0, 16'd21845, 16'd65535, 8'd255, 1'b0},
        {1'b1, 8'd0,   8'd0,   8'd255, 1'b1, 16'd43690, 16'd65535, 8'd255, 1'b1},
        {1'b1, 8'd1,   8'd0,   8'd0,   1'b0, 16'd0,     16'd65535, 8'd1,   1'b0},
        {1'b1, 8'd0,   8'd255, 8'd255, 1'b0, 16'd32768, 16'd65535, 8'd255, 1'b0},
        {1'b0, 8'd255, 8'd255, 8'd0,   1'b0, 41'd0},
        {1'b0, 8'd255, 8'd0,   8'd255, 1'b0, 41'd0},
        {1'b0, 8'd255, 8'd0,   8'd1,   1'b0, 41'd0},
        {1'b0, 8'd255, 8'd0,   8'd254, 1'b1, 41'd0},
        {1'b0, 8'd255, 8'd128, 8'd0,   1'b0, 41'd0},
        {1'b0, 8'd0,   8'd128, 8'd255, 1'b0, 41'd0},
        {1'b0, 8'd200, 8'd100, 8'd150, 1'b0, 41'd0},
        {1'b0, 8'd1,   8'd2,   8'd3,   1'b0, 41'd0},
        {1'b0, 8'd254, 8'd255, 8'd254, 1'b0, 41'd0},
        {1'b0, 8'd255, 8'd254, 8'd255, 1'b1, 41'd0},
        {1'b0, 8'd128, 8'd64,  8'd255, 1'b0, 41'd0},
        {1'b0, 8'd170, 8'd85,  8'd0,   1'b0, 41'd0}
    };

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             pixel_valid = 1'b0;
    logic             pixel_ready;
    rhsv_pkg::pixel_t pixel       = '0;
    logic             hsv_valid;
    logic             hsv_ready   = 1'b0;
    rhsv_pkg::hsv_t   hsv;

    rhsv_pkg::hsv_t   pending_hsv [$];
    int               mismatches  = 0;
    bit               no_idle     = 1'b0;
    bit               hold_req    = 1'b0;

    rgb_to_hsv_hexcone i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .hsv_valid   (hsv_valid),
        .hsv_ready   (hsv_ready),
        .hsv         (hsv)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rhsv_pkg::hsv_t hexcone_hsv(input rhsv_pkg::pixel_t px);
        longint         chan [3];
        longint         top;
        longint         bottom;
        longint         spread;
        longint         arc;
        longint         frac;
        logic [1:0]     sector;
        rhsv_pkg::hsv_t res;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        top     = 0;
        bottom  = 255;
        sector  = rhsv_pkg::SEL_RED;
        for (int k = 0; k < 3; k++)
        begin
            // later channel wins a tie for the maximum
            if (chan[k] >= top)
            begin
                top    = chan[k];
                sector = 2'(k);
            end
            if (chan[k] <= bottom)
                bottom = chan[k];
        end
        spread            = top - bottom;
        res               = '0;
        res.value         = top[7:0];
        res.frame_end_out = px.frame_end;
        if (top != 0)
        begin
            frac           = (spread * 65536) / top;
            res.saturation = (frac > 65535) ? 16'hFFFF : frac[15:0];
            if (spread != 0)
            begin
                case (sector)
                    rhsv_pkg::SEL_RED:   arc = chan[1] - chan[2];
                    rhsv_pkg::SEL_GREEN: arc = 2 * spread + chan[2] - chan[0];
                    default:             arc = 4 * spread + chan[0] - chan[1];
                endcase
                if (arc < 0)
                    arc += 6 * spread;
                frac    = (arc * 65536) / (6 * spread);
                res.hue = frac[15:0];
            end
        end
        return res;
    endfunction

    // entered and left at a falling edge
    task automatic drive_pixel(input rhsv_pkg::pixel_t px, input rhsv_pkg::hsv_t want);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do
            @(posedge clk);
        while (!pixel_ready);
        pending_hsv.push_back(want);
        @(negedge clk);
    endtask

    initial
    begin
        rhsv_pkg::pixel_t px;
        int unsigned      lvl;
        int unsigned      lo;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            drive_pixel(DIR_ROWS[i].px,
                        DIR_ROWS[i].typed ? DIR_ROWS[i].hsv : hexcone_hsv(DIR_ROWS[i].px));

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == CALM_FIRST)
                no_idle = 1'b1;
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (i == CALM_LAST)
                no_idle = 1'b0;
            if (i == PAUSE_AT)
            begin
                pixel_valid <= 1'b0;
                while (pending_hsv.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            px.red       = 8'($urandom);
            px.green     = 8'($urandom);
            px.blue      = 8'($urandom);
            px.frame_end = ($urandom_range(15) == 0);
            case ($urandom_range(9))
                0:
                begin
                    lvl      = $urandom_range(255);
                    px.red   = 8'(lvl);
                    px.green = 8'(lvl);
                    px.blue  = 8'(lvl);
                end
                1:
                begin
                    lvl = $urandom_range(255, 1);
                    lo  = $urandom_range(lvl);
                    case ($urandom_range(2))
                        0:       px = {8'(lvl), 8'(lvl), 8'(lo), px.frame_end};
                        1:       px = {8'(lo), 8'(lvl), 8'(lvl), px.frame_end};
                        default: px = {8'(lvl), 8'(lo), 8'(lvl), px.frame_end};
                    endcase
                end
                2:
                    case ($urandom_range(2))
                        0:       px.red   = '0;
                        1:       px.green = '0;
                        default: px.blue  = '0;
                    endcase
                3:
                    case ($urandom_range(2))
                        0:       px.red   = '1;
                        1:       px.green = '1;
                        default: px.blue  = '1;
                    endcase
                4:
                begin
                    px.red   = 8'($urandom_range(3));
                    px.green = 8'($urandom_range(3));
                    px.blue  = 8'($urandom_range(3));
                end
                default: ;
            endcase
            drive_pixel(px, hexcone_hsv(px));
        end

        pixel_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hsv_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                hsv_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        rhsv_pkg::hsv_t want;
        if (rst_n && hsv_valid && hsv_ready)
        begin
            if (pending_hsv.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected beat: hue %0d sat %0d value %0d fe %0b",
                             hsv.hue, hsv.saturation, hsv.value, hsv.frame_end_out);
                mismatches++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (hsv.hue !== want.hue || hsv.saturation !== want.saturation ||
                    hsv.value !== want.value || hsv.frame_end_out !== want.frame_end_out)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.hue, want.saturation, want.value, want.frame_end_out,
                                 hsv.hue, hsv.saturation, hsv.value, hsv.frame_end_out);
                    mismatches++;
                end
            end
        end
    end

    // ends the run after too many cycles with no beat on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
